// File: rtl/core/hvd_pkg.sv
package hvd_pkg;

    // Pipeline depth and angle format
    localparam int CORDIC_STAGES   = 24;
    localparam int ANGLE_FRAC_BITS = 22;
    localparam int STG_W           = $clog2(CORDIC_STAGES);

    // Datapath widths
    localparam int CW          = 34;
    localparam int SQRT_STEPS  = 31;
    localparam int SQ_STG_W    = $clog2(SQRT_STEPS);
    localparam int SQ_W        = 62;
    localparam int RADIUS_W    = 24;
    localparam int DIST_W      = 42;
    localparam int RAD_SH      = ANGLE_FRAC_BITS + 6;
    localparam int DIST_SH     = 14;

    // Angle constants: turns in degrees with 22 fraction bits, pi terms in Q30 radians
    localparam int HALF_TURN_DEG = 180;
    localparam int HALF_DIVISOR  = 2;
    localparam longint HALF_TURN_Q = longint'(HALF_TURN_DEG) << ANGLE_FRAC_BITS;
    localparam longint TURN_Q      = longint'(2 * HALF_TURN_DEG) << ANGLE_FRAC_BITS;
    localparam logic [30:0] DEG2RAD_Q36     = 31'd1199381129;
    localparam logic [31:0] PI_Q30          = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [30:0] ONE_Q30         = 31'd1073741824;
    localparam logic [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    // Register map
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371;
    localparam logic [2:0]          ADDR_RADIUS  = 3'd0;

    // One CORDIC word: x, y and residual angle
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    // One root step: remainder and partial root
    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sqrt_t;

    // atan(2^-i) truncated to Q30
    function automatic logic signed [CW-1:0] atan_q30(input logic [STG_W-1:0] i);
        logic signed [CW-1:0] a;
        case (i)
            0:       a = CW'(843314856);
            1:       a = CW'(497837829);
            2:       a = CW'(263043836);
            3:       a = CW'(133525158);
            4:       a = CW'(67021686);
            5:       a = CW'(33543515);
            6:       a = CW'(16775850);
            7:       a = CW'(8388437);
            8:       a = CW'(4194282);
            9:       a = CW'(2097149);
            default: begin
                if (int'(i) <= 30) begin
                    a = CW'((64'sd1 <<< (30 - int'(i))) - 64'sd1);
                end else begin
                    a = '0;
                end
            end
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/hvd_cordic_cell.sv
module hvd_cordic_cell
    import hvd_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic             vec_mode,
    input  logic [STG_W-1:0] stage,
    input  cordic_t          cin,
    output cordic_t          cout
);

    logic signed [CW-1:0] sx, sy, at;
    logic                 dir;
    cordic_t              st_next, st_reg;

    // One micro-rotation; direction from angle sign or from y sign
    always_comb begin
        sx  = $signed(cin.x) >>> stage;
        sy  = $signed(cin.y) >>> stage;
        at  = atan_q30(stage);
        dir = vec_mode ? cin.y[CW-1] : ~cin.z[CW-1];
        if (dir) begin
            st_next.x = $signed(cin.x) - sy;
            st_next.y = $signed(cin.y) + sx;
            st_next.z = $signed(cin.z) - at;
        end else begin
            st_next.x = $signed(cin.x) + sy;
            st_next.y = $signed(cin.y) - sx;
            st_next.z = $signed(cin.z) + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign cout = st_reg;

endmodule

// File: rtl/core/hvd_sqrt_cell.sv
module hvd_sqrt_cell
    import hvd_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [SQ_STG_W-1:0] stage,
    input  sqrt_t               qin,
    output sqrt_t               qout
);

    logic [SQ_W-1:0] bitv, trial;
    sqrt_t           st_next, st_reg;

    // One root digit: trial subtract of r + bit
    always_comb begin
        bitv  = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - int'(stage)));
        trial = qin.r + bitv;
        if (qin.v >= trial) begin
            st_next.v = qin.v - trial;
            st_next.r = (qin.r >> 1) + bitv;
        end else begin
            st_next.v = qin.v;
            st_next.r = qin.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign qout = st_reg;

endmodule

// File: rtl/core/haversine_distance.sv
// Haversine great-circle distance and kd-tree one-axis bound distance.
// Input words arrive on s_t*: tdata carries lng_a, lat_a, lng_b, lat_b in
// degrees with 22 fraction bits, tuser carries command and axis. Command 0
// gives the haversine distance, command 1 the bound on the axis in tuser[1].
// Results leave on m_t*: distance in radius units, 16 fraction bits.
// The sphere radius sits in the APB register at byte address 0.
// The datapath is one pipeline from an accepted word to its result word;
// it holds four rows of 24 rotation cells, two rows of 31 root cells and
// one row of 24 vectoring cells, one word per clock through unless stalled.
// A new word is taken every cycle while the output register is empty or is
// being drained. When m_tready is low with a result waiting, the whole pipe
// holds and s_tready falls; nothing is dropped and bubbles stay in place.
// Reset empties the pipe, clears m_tvalid and loads the radius 6371.
module haversine_distance
    import hvd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // tdata: lng_a[30:0], lat_a[60:31], lng_b[91:61], lat_b[121:92], zero pad
    input  logic [127:0]  s_tdata,
    // tuser: command[0], axis[1]
    input  logic [1:0]    s_tuser,
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: distance[41:0], zero pad
    output logic [47:0]   m_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int NROT  = CORDIC_STAGES;
    localparam int P_Q4  = 6 + NROT + 3;
    localparam int NPIPE = 2 * CORDIC_STAGES + SQRT_STEPS + 13;

    typedef struct packed {
        logic        cmd;
        logic        axis;
        logic [33:0] rad;
        logic        neg_a;
        logic        neg_b;
    } rot_side_t;

    typedef struct packed {
        logic        cmd;
        logic [58:0] bp;
    } tail_side_t;

    logic                 ce;
    logic [NPIPE-1:0]     vld_reg;
    logic                 m_tvalid_reg;
    logic [RADIUS_W-1:0]  radius_reg;
    logic [DIST_W-1:0]    m_dist_reg;

    logic signed [30:0]   in_lng_a, in_lng_b;
    logic signed [29:0]   in_lat_a, in_lat_b;

    // stage registers
    logic signed [30:0]   s1_dlat_reg;
    logic signed [31:0]   s1_dlng_reg, s1_bnd_reg;
    logic [29:0]          s1_mla_reg, s1_mlb_reg;
    logic                 s1_cmd_reg, s1_axis_reg;
    logic signed [30:0]   s2_rlat_reg, s2_rlng_reg;
    logic [30:0]          s2_mbnd_reg;
    logic [29:0]          s2_mla_reg, s2_mlb_reg;
    logic                 s2_cmd_reg, s2_axis_reg;
    logic [29:0]          s3_mlat_reg, s3_mlng_reg, s3_mla_reg, s3_mlb_reg;
    logic [30:0]          s3_mbnd_reg;
    logic                 s3_cmd_reg, s3_axis_reg;
    logic [60:0]          s4_plat_reg, s4_plng_reg, s4_pla_reg, s4_plb_reg;
    logic [61:0]          s4_pbnd_reg;
    logic                 s4_cmd_reg, s4_axis_reg;
    logic [30:0]          s5_thlat_reg, s5_thlng_reg;
    logic [31:0]          s5_thla_reg, s5_thlb_reg;
    logic [33:0]          s5_rad_reg;
    logic                 s5_cmd_reg, s5_axis_reg;
    cordic_t              rot_in_reg [4];
    rot_side_t            rot_side_reg [NROT+1];
    logic signed [31:0]   q1_ca_reg, q1_cb_reg;
    logic signed [63:0]   q1_s1sq_reg, q1_s2sq_reg;
    rot_side_t            q1_side_reg;
    logic signed [63:0]   q2_ccp_reg;
    logic signed [32:0]   q2_s1h_reg, q2_s2h_reg;
    logic [64:0]          q2_bprod_reg;
    logic                 q2_fpos_reg;
    rot_side_t            q2_side_reg;
    logic signed [65:0]   q3_ap_reg;
    logic signed [32:0]   q3_s1h_reg;
    logic [34:0]          q3_t_reg;
    rot_side_t            q3_side_reg;
    logic [30:0]          q4_a_reg;
    logic [34:0]          q4_bm_reg;
    logic                 q4_cmd_reg;
    sqrt_t                sqrt_in_reg [2];
    tail_side_t           tail_reg [SQRT_STEPS+NROT+1];
    logic [31:0]          v1_c_reg;
    tail_side_t           v1_side_reg;
    logic [58:0]          m1_p_reg;

    // combinational helpers
    logic signed [30:0]   red_lat, red_lng;
    logic signed [31:0]   xa, xb, ya, yb;
    logic signed [32:0]   cc;
    logic signed [35:0]   a_sum, ap_s;
    logic [30:0]          a_clamp;
    logic [30:0]          z_lat, z_lng;
    logic [31:0]          z_la, z_lb;
    logic                 neg_la, neg_lb;
    logic signed [CW-1:0] vz;
    logic [30:0]          zc;
    logic [59:0]          rnd;

    cordic_t              rot_w [4][NROT+1];
    sqrt_t                sq_w  [2][SQRT_STEPS+1];
    cordic_t              vec_w [NROT+1];

    // handshake: the whole pipe moves when the output register can move
    assign ce       = ~m_tvalid_reg | m_tready;
    assign s_tready = ce;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_dist_reg};

    assign in_lng_a = s_tdata[30:0];
    assign in_lat_a = s_tdata[60:31];
    assign in_lng_b = s_tdata[91:61];
    assign in_lat_b = s_tdata[121:92];

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RADIUS) ? {8'b0, radius_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_RADIUS) begin
            radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg      <= {vld_reg[NPIPE-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[NPIPE-1];
        end
    end

    // wrap a degree difference into [-180, 180)
    function automatic logic signed [30:0] reduce_turn(input logic signed [32:0] d);
        logic signed [32:0] r;
        if (d >= HALF_TURN_Q) begin
            r = d - 33'(TURN_Q);
        end else if (d < -HALF_TURN_Q) begin
            r = d + 33'(TURN_Q);
        end else begin
            r = d;
        end
        return 31'(r);
    endfunction

    // front-end combinational terms
    always_comb begin
        red_lat = reduce_turn(33'(s1_dlat_reg));
        red_lng = reduce_turn(33'(s1_dlng_reg));

        // sine lanes clamp to pi/2; cosine lanes fold past pi/2
        z_lat  = (s5_thlat_reg > HALF_PI_Q30) ? HALF_PI_Q30 : s5_thlat_reg;
        z_lng  = (s5_thlng_reg > HALF_PI_Q30) ? HALF_PI_Q30 : s5_thlng_reg;
        neg_la = s5_thla_reg > 32'(HALF_PI_Q30);
        neg_lb = s5_thlb_reg > 32'(HALF_PI_Q30);
        z_la   = s5_thla_reg;
        z_lb   = s5_thlb_reg;
        if (neg_la) begin
            z_la = (s5_thla_reg > PI_Q30) ? '0 : PI_Q30 - s5_thla_reg;
        end
        if (neg_lb) begin
            z_lb = (s5_thlb_reg > PI_Q30) ? '0 : PI_Q30 - s5_thlb_reg;
        end

        xa = 32'(rot_w[2][NROT].x);
        xb = 32'(rot_w[3][NROT].x);
        ya = 32'(rot_w[0][NROT].y);
        yb = 32'(rot_w[1][NROT].y);

        cc    = $signed(q2_ccp_reg[62:30]);
        ap_s  = $signed(q3_ap_reg[65:30]);
        a_sum = 36'(q3_s1h_reg) + ap_s;
        if (a_sum[35]) begin
            a_clamp = '0;
        end else if (a_sum[34:0] > 35'(ONE_Q30)) begin
            a_clamp = ONE_Q30;
        end else begin
            a_clamp = a_sum[30:0];
        end

        vz = $signed(vec_w[NROT].z);
        if (vz[CW-1]) begin
            zc = '0;
        end else if (vz[CW-2:0] > (CW-1)'(HALF_PI_Q30)) begin
            zc = HALF_PI_Q30;
        end else begin
            zc = vz[30:0];
        end

        rnd = (60'(m1_p_reg) + (60'(1) << (DIST_SH - 1))) >> DIST_SH;
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (ce) begin
            // differences and latitude magnitudes
            s1_dlat_reg <= 31'(in_lat_b) - 31'(in_lat_a);
            s1_dlng_reg <= 32'(in_lng_b) - 32'(in_lng_a);
            s1_bnd_reg  <= s_tuser[1] ? 32'(in_lat_a) - 32'(in_lat_b)
                                      : 32'(in_lng_a) - 32'(in_lng_b);
            s1_mla_reg  <= in_lat_a[29] ? 30'(-in_lat_a) : 30'(in_lat_a);
            s1_mlb_reg  <= in_lat_b[29] ? 30'(-in_lat_b) : 30'(in_lat_b);
            s1_cmd_reg  <= s_tuser[0];
            s1_axis_reg <= s_tuser[1];

            // wrap, bound magnitude
            s2_rlat_reg <= red_lat;
            s2_rlng_reg <= red_lng;
            s2_mbnd_reg <= s1_bnd_reg[31] ? 31'(-s1_bnd_reg) : 31'(s1_bnd_reg);
            s2_mla_reg  <= s1_mla_reg;
            s2_mlb_reg  <= s1_mlb_reg;
            s2_cmd_reg  <= s1_cmd_reg;
            s2_axis_reg <= s1_axis_reg;

            // magnitudes of wrapped differences
            s3_mlat_reg <= s2_rlat_reg[30] ? 30'(-s2_rlat_reg) : 30'(s2_rlat_reg);
            s3_mlng_reg <= s2_rlng_reg[30] ? 30'(-s2_rlng_reg) : 30'(s2_rlng_reg);
            s3_mla_reg  <= s2_mla_reg;
            s3_mlb_reg  <= s2_mlb_reg;
            s3_mbnd_reg <= s2_mbnd_reg;
            s3_cmd_reg  <= s2_cmd_reg;
            s3_axis_reg <= s2_axis_reg;

            // degrees to radians
            s4_plat_reg <= 61'(s3_mlat_reg) * 61'(DEG2RAD_Q36);
            s4_plng_reg <= 61'(s3_mlng_reg) * 61'(DEG2RAD_Q36);
            s4_pla_reg  <= 61'(s3_mla_reg) * 61'(DEG2RAD_Q36);
            s4_plb_reg  <= 61'(s3_mlb_reg) * 61'(DEG2RAD_Q36);
            s4_pbnd_reg <= 62'(s3_mbnd_reg) * 62'(DEG2RAD_Q36);
            s4_cmd_reg  <= s3_cmd_reg;
            s4_axis_reg <= s3_axis_reg;

            // rounding; half angles take one more shift
            s5_thlat_reg <= 31'((s4_plat_reg + (61'(1) << RAD_SH)) >> (RAD_SH + 1));
            s5_thlng_reg <= 31'((s4_plng_reg + (61'(1) << RAD_SH)) >> (RAD_SH + 1));
            s5_thla_reg  <= 32'((s4_pla_reg + (61'(1) << (RAD_SH - 1))) >> RAD_SH);
            s5_thlb_reg  <= 32'((s4_plb_reg + (61'(1) << (RAD_SH - 1))) >> RAD_SH);
            s5_rad_reg   <= 34'((s4_pbnd_reg + (62'(1) << (RAD_SH - 1))) >> RAD_SH);
            s5_cmd_reg   <= s4_cmd_reg;
            s5_axis_reg  <= s4_axis_reg;

            // rotation rows start: lanes dlat, dlng, lat_a, lat_b
            rot_in_reg[0] <= '{x: CORDIC_GAIN_Q30, y: '0, z: CW'(z_lat)};
            rot_in_reg[1] <= '{x: CORDIC_GAIN_Q30, y: '0, z: CW'(z_lng)};
            rot_in_reg[2] <= '{x: CORDIC_GAIN_Q30, y: '0, z: CW'(z_la)};
            rot_in_reg[3] <= '{x: CORDIC_GAIN_Q30, y: '0, z: CW'(z_lb)};
            rot_side_reg[0] <= '{cmd: s5_cmd_reg, axis: s5_axis_reg, rad: s5_rad_reg,
                                 neg_a: neg_la, neg_b: neg_lb};
            for (int k = NROT; k > 0; k--) begin
                rot_side_reg[k] <= rot_side_reg[k-1];
            end

            // signed cosines and squared sines
            q1_ca_reg   <= rot_side_reg[NROT].neg_a ? -xa : xa;
            q1_cb_reg   <= rot_side_reg[NROT].neg_b ? -xb : xb;
            q1_s1sq_reg <= 64'(ya) * 64'(ya);
            q1_s2sq_reg <= 64'(yb) * 64'(yb);
            q1_side_reg <= rot_side_reg[NROT];

            // cos product, bound times cos(lat_b)
            q2_ccp_reg   <= 64'(q1_ca_reg) * 64'(q1_cb_reg);
            q2_s1h_reg   <= $signed({1'b0, q1_s1sq_reg[61:30]});
            q2_s2h_reg   <= $signed({1'b0, q1_s2sq_reg[61:30]});
            q2_bprod_reg <= 65'(q1_side_reg.rad) * 65'(q1_cb_reg[30:0]);
            q2_fpos_reg  <= ~q1_cb_reg[31] & (q1_cb_reg != '0);
            q2_side_reg  <= q1_side_reg;

            // cos product times sin^2(dlng/2)
            q3_ap_reg   <= 66'(cc) * 66'(q2_s2h_reg);
            q3_s1h_reg  <= q2_s1h_reg;
            q3_t_reg    <= q2_fpos_reg ? 35'((q2_bprod_reg + (65'(1) << 29)) >> 30) : '0;
            q3_side_reg <= q2_side_reg;

            // a clamped to [0, 1]; bound operand
            q4_a_reg   <= a_clamp;
            q4_bm_reg  <= q3_side_reg.axis ? 35'(q3_side_reg.rad) : q3_t_reg;
            q4_cmd_reg <= q3_side_reg.cmd;

            // root rows start; bound times radius
            sqrt_in_reg[0] <= '{v: SQ_W'(q4_a_reg) << 30, r: '0};
            sqrt_in_reg[1] <= '{v: SQ_W'(ONE_Q30 - q4_a_reg) << 30, r: '0};
            tail_reg[0]    <= '{cmd: q4_cmd_reg,
                                bp: 59'(q4_bm_reg) * 59'(radius_reg)};
            for (int k = SQRT_STEPS + NROT; k > 0; k--) begin
                tail_reg[k] <= tail_reg[k-1];
            end

            // central angle
            v1_c_reg    <= 32'(zc * HALF_DIVISOR);
            v1_side_reg <= tail_reg[SQRT_STEPS+NROT];

            // scale by radius or pass the bound
            m1_p_reg <= v1_side_reg.cmd ? v1_side_reg.bp
                                        : 59'(radius_reg) * 59'(v1_c_reg);

            // round and saturate
            m_dist_reg <= (rnd > 60'(DIST_MAX)) ? DIST_MAX : rnd[DIST_W-1:0];
        end
    end

    // rotation rows
    for (genvar l = 0; l < 4; l++) begin : g_rot_lane
        assign rot_w[l][0] = rot_in_reg[l];
        for (genvar g = 0; g < NROT; g++) begin : g_rot_cell
            hvd_cordic_cell u_cell (
                .aclk     (aclk),
                .en       (ce),
                .vec_mode (1'b0),
                .stage    (STG_W'(g)),
                .cin      (rot_w[l][g]),
                .cout     (rot_w[l][g+1])
            );
        end
    end

    // root rows: sqrt(a) and sqrt(1 - a)
    for (genvar l = 0; l < 2; l++) begin : g_sq_lane
        assign sq_w[l][0] = sqrt_in_reg[l];
        for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sq_cell
            hvd_sqrt_cell u_cell (
                .aclk  (aclk),
                .en    (ce),
                .stage (SQ_STG_W'(g)),
                .qin   (sq_w[l][g]),
                .qout  (sq_w[l][g+1])
            );
        end
    end

    // vectoring row: atan2(sqrt(a), sqrt(1 - a))
    assign vec_w[0] = '{x: CW'(sq_w[1][SQRT_STEPS].r), y: CW'(sq_w[0][SQRT_STEPS].r), z: '0};
    for (genvar g = 0; g < NROT; g++) begin : g_vec_cell
        hvd_cordic_cell u_cell (
            .aclk     (aclk),
            .en       (ce),
            .vec_mode (1'b1),
            .stage    (STG_W'(g)),
            .cin      (vec_w[g]),
            .cout     (vec_w[g+1])
        );
    end

    // checks
    a_reset_empty: assert property (@(posedge aclk) $rose(aresetn) |-> !m_tvalid)
        else $error("result word valid right after reset");
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word missing from pipe");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg))
        else $error("pipe moved during stall");
    a_clamp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[P_Q4] |-> q4_a_reg <= ONE_Q30)
        else $error("haversine term above one");

endmodule

// File: bench/haversine_distance_tb.sv
`timescale 1ns / 100ps

module haversine_distance_tb;

    // Angle ranges, degrees with 22 fraction bits
    localparam int LNG_MAX = 754974720;
    localparam int LAT_MAX = 377487360;
    // Q30 radian constants and the fixed CORDIC start value
    localparam longint DEG2RAD   = 64'd1199381129;
    localparam longint PI_Q      = 64'd3373259426;
    localparam longint HALF_PI_Q = 64'd1686629713;
    localparam longint ONE_Q     = 64'd1073741824;
    localparam longint GAIN_Q    = 64'd652032874;
    localparam longint unsigned DIST_CAP = 64'd4398046511103;
    localparam longint unsigned U64_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int STAGES    = 24;
    localparam int FRAC      = 22;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LEN  = 400;

    // Commands and register addresses
    localparam logic CMD_HAVERSINE = 1'b0;
    localparam logic CMD_BOUND     = 1'b1;
    localparam logic AXIS_LNG      = 1'b0;
    localparam logic AXIS_LAT      = 1'b1;
    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_NONE   = 3'd4;

    typedef struct {
        logic               cmd;
        logic               axis;
        logic signed [30:0] lng_a;
        logic signed [29:0] lat_a;
        logic signed [30:0] lng_b;
        logic signed [29:0] lat_b;
    } point_pair_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic [127:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    point_pair_t       pending_pairs[$];
    logic [41:0]       expected_dist[$];
    longint unsigned   radius_model = 6371;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                errors = 0;
    int                n_words_in = 0;
    int                n_words_out = 0;
    int                n_haversine = 0;
    int                n_bound = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    int                wdog = 0;

    haversine_distance u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    // round(a*b / 2^sh), saturated at cap
    function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b,
                                                  int sh, longint unsigned cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        return (p > {64'd0, cap}) ? cap : p[63:0];
    endfunction

    function automatic longint atan_step(int i);
        longint head[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                             33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10) return head[i];
        if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
        return 0;
    endfunction

    // wrap into [-180, 180) degrees
    function automatic longint wrap_deg(longint d);
        longint m;
        longint r;
        m = longint'(360) << FRAC;
        r = d % m;
        if (r < 0) r += m;
        if (r >= m / 2) r -= m;
        return r;
    endfunction

    function automatic longint unsigned to_rad(longint unsigned mag, int extra);
        return mul_round(mag, DEG2RAD, FRAC + 6 + extra, U64_MAX);
    endfunction

    // rotation mode: z in [0, pi/2] -> cos, sin
    function automatic void rotate(input longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = GAIN_Q;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint cos_deg(longint deg);
        longint r;
        longint th;
        longint c;
        longint s;
        r = wrap_deg(deg);
        th = longint'(to_rad((r < 0) ? -r : r, 0));
        if (th > PI_Q) th = PI_Q;
        if (th > HALF_PI_Q) begin
            rotate(PI_Q - th, c, s);
            return -c;
        end
        rotate(th, c, s);
        return c;
    endfunction

    function automatic longint sin_half_squared(longint d);
        longint r;
        longint th;
        longint c;
        longint s;
        r = wrap_deg(d);
        th = longint'(to_rad((r < 0) ? -r : r, 1));
        if (th > HALF_PI_Q) th = HALF_PI_Q;
        rotate(th, c, s);
        return (s * s) >>> 30;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring mode: atan2(y, x), clamped to [0, pi/2]
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > HALF_PI_Q) z = HALF_PI_Q;
        return z;
    endfunction

    function automatic logic [41:0] predict_distance(point_pair_t p, longint unsigned radius);
        longint s1;
        longint s2;
        longint cc;
        longint a;
        longint c;
        longint f;
        longint delta;
        longint unsigned rad;
        longint unsigned t;
        longint unsigned dist_val;
        if (p.cmd == CMD_HAVERSINE) begin
            s1 = sin_half_squared(longint'(p.lat_b) - longint'(p.lat_a));
            s2 = sin_half_squared(longint'(p.lng_b) - longint'(p.lng_a));
            cc = (cos_deg(longint'(p.lat_a)) * cos_deg(longint'(p.lat_b))) >>> 30;
            a = s1 + ((cc * s2) >>> 30);
            if (a < 0) a = 0;
            if (a > ONE_Q) a = ONE_Q;
            c = 2 * vector_angle(longint'(int_sqrt(a << 30)),
                                 longint'(int_sqrt((ONE_Q - a) << 30)));
            dist_val = mul_round(radius, c, 14, DIST_CAP);
        end else begin
            delta = (p.axis == AXIS_LAT) ? longint'(p.lat_a) - longint'(p.lat_b)
                                         : longint'(p.lng_a) - longint'(p.lng_b);
            rad = to_rad((delta < 0) ? -delta : delta, 0);
            if (p.axis == AXIS_LAT) begin
                dist_val = mul_round(rad, radius, 14, DIST_CAP);
            end else begin
                f = cos_deg(longint'(p.lat_b));
                if (f <= 0) begin
                    dist_val = 0;
                end else begin
                    t = mul_round(rad, f, 30, U64_MAX);
                    dist_val = mul_round(t, radius, 14, DIST_CAP);
                end
            end
        end
        return dist_val[41:0];
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic point_pair_t make_pair(logic cmd, logic axis, int lnga, int lata,
                                              int lngb, int latb);
        point_pair_t p;
        p.cmd = cmd;
        p.axis = axis;
        p.lng_a = 31'(lnga);
        p.lat_a = 30'(lata);
        p.lng_b = 31'(lngb);
        p.lat_b = 30'(latb);
        return p;
    endfunction

    function automatic int rand_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // mostly far-apart points, some close pairs for fine resolution
    function automatic point_pair_t random_pair();
        point_pair_t p;
        int lnga;
        int lata;
        lnga = rand_span(LNG_MAX);
        lata = rand_span(LAT_MAX);
        p.cmd = 1'($urandom_range(0, 1));
        p.axis = 1'($urandom_range(0, 1));
        p.lng_a = 31'(lnga);
        p.lat_a = 30'(lata);
        if ($urandom_range(0, 3) == 0) begin
            p.lng_b = (lnga + rand_span(1 << 16) > LNG_MAX) ? 31'(LNG_MAX)
                    : (lnga + rand_span(1 << 16) < -LNG_MAX) ? 31'(-LNG_MAX)
                    : 31'(lnga + rand_span(1 << 16));
            p.lat_b = (lata > LAT_MAX - 70000) ? 30'(LAT_MAX)
                    : (lata < -LAT_MAX + 70000) ? 30'(-LAT_MAX)
                    : 30'(lata + rand_span(1 << 16));
        end else begin
            p.lng_b = 31'(rand_span(LNG_MAX));
            p.lat_b = 30'(rand_span(LAT_MAX));
        end
        return p;
    endfunction

    // APB write: setup then access cycle
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_RADIUS) radius_model = data[23:0];
    endtask

    task automatic drain_all();
        while (pending_pairs.size() != 0 || expected_dist.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input logic [41:0] got, input logic [41:0] want);
        $display("mismatch at word %0d: distance got %0d expected %0d",
                 n_words_out, got, want);
        errors++;
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                point_pair_t p;
                p = pending_pairs.pop_front();
                s_tdata <= {6'd0, p.lat_b, p.lng_b, p.lat_a, p.lng_a};
                s_tuser <= {p.axis, p.cmd};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ready, with one long hold-off ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && n_words_out >= 1000) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                point_pair_t p;
                p.lng_a = s_tdata[30:0];
                p.lat_a = s_tdata[60:31];
                p.lng_b = s_tdata[91:61];
                p.lat_b = s_tdata[121:92];
                p.cmd = s_tuser[0];
                p.axis = s_tuser[1];
                expected_dist.push_back(predict_distance(p, radius_model));
                n_words_in++;
                if (p.cmd == CMD_HAVERSINE) n_haversine++;
                else n_bound++;
            end
            if (m_tvalid && m_tready) begin
                logic [41:0] want;
                if (expected_dist.size() == 0) begin
                    $display("result word %0d arrived with nothing expected", n_words_out);
                    errors++;
                end else begin
                    want = expected_dist.pop_front();
                    if (m_tdata[41:0] !== want) report_mismatch(m_tdata[41:0], want);
                end
                n_words_out++;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("FAIL haversine_distance");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: reset radius, directed corners
        send_idle_pct = 34;
        recv_idle_pct = 53;
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LAT, LNG_MAX, LAT_MAX,
                                          -LNG_MAX, -LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, -LNG_MAX, 0, LNG_MAX, 0));
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, 0, 0, LNG_MAX, 0));
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, 0, LAT_MAX, 0, -LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, 100, LAT_MAX, -100, LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, 1, -1, -1, 1));
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, -LNG_MAX, -LAT_MAX,
                                          -LNG_MAX, -LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LNG, LNG_MAX, 0, -LNG_MAX, 0));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LNG, -LNG_MAX, 0, LNG_MAX, LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LNG, LNG_MAX, 0, -LNG_MAX, -LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LNG, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LAT, 0, LAT_MAX, 0, -LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LAT, 0, -LAT_MAX, 0, LAT_MAX));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LAT, LNG_MAX, 5, -LNG_MAX, 5));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LNG, 7, LAT_MAX, -7, 1234567));
        drain_all();

        // phase 2: largest radius, saturation territory
        apb_write(REG_RADIUS, 32'hFFFF_FFFF);
        pending_pairs.push_back(make_pair(CMD_HAVERSINE, AXIS_LNG, -LNG_MAX, 0, 0, 0));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LNG, LNG_MAX, 0, -LNG_MAX, 0));
        pending_pairs.push_back(make_pair(CMD_BOUND, AXIS_LAT, 0, LAT_MAX, 0, -LAT_MAX));
        for (int i = 0; i < 380; i++) pending_pairs.push_back(random_pair());
        drain_all();

        // phase 3: smallest radius, unmapped write ignored, idles swapped
        apb_write(REG_RADIUS, 32'd1);
        apb_write(REG_NONE, 32'h00AB_CDEF);
        send_idle_pct = 53;
        recv_idle_pct = 34;
        for (int i = 0; i < 400; i++) pending_pairs.push_back(random_pair());
        drain_all();

        // phase 4: random radius, no idling, long receiver hold-off lands here
        apb_write(REG_RADIUS, $urandom_range(1, 24'hFFFFFF));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 450; i++) pending_pairs.push_back(random_pair());
        drain_all();

        repeat (200) @(posedge aclk);
        $display("covered %0d words: %0d haversine, %0d bound, over four radius settings",
                 n_words_in, n_haversine, n_bound);
        $display("idle mixes on both sides plus one %0d-cycle output hold-off", HOLD_LEN);
        if (errors == 0 && expected_dist.size() == 0) begin
            $display("PASS haversine_distance");
        end else begin
            $display("FAIL haversine_distance");
        end
        $finish;
    end

endmodule
